// ===== src/evt_pkg.sv =====
// Shared types and constants of the eased value transition block.
// Holds the controller/datapath command and status structs and helpers.
// Depends on nothing.
package evt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int VAL_W      = 26;
  localparam int PT_W       = 36;
  localparam int TOL        = 429;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION = 3'd0,
    CFG_X1       = 3'd1,
    CFG_Y1       = 3'd2,
    CFG_X2       = 3'd3,
    CFG_Y2       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic load_in;
    logic decide;
    logic div_step;
    logic bis_init;
    logic bis_a;
    logic bis_b;
    logic mul_lo;
    logic mul_hi;
    logic final_add;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_ease;
    logic div_last;
    logic bis_done;
  } dp_sts_t;

  // Floor of half of a grown sum, back to the curve point width.
  function automatic logic signed [PT_W-1:0] half_floor(input logic signed [PT_W:0] s);
    logic signed [PT_W:0] h;
    h = s >>> 1;
    return h[PT_W-1:0];
  endfunction

endpackage

// ===== src/evt_ctrl.sv =====
// Controller state machine of the eased value transition block.
// Sequences the datapath and owns the request handshakes; uses evt_pkg.
module evt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output evt_pkg::dp_cmd_t cmd,
  input  evt_pkg::dp_sts_t sts
);
  import evt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECIDE = 10'b0000000010,
    S_DIV    = 10'b0000000100,
    S_BINIT  = 10'b0000001000,
    S_BA     = 10'b0000010000,
    S_BB     = 10'b0000100000,
    S_MLO    = 10'b0001000000,
    S_MHI    = 10'b0010000000,
    S_FINAL  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.need_ease ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_BINIT;
      end
      S_BINIT: begin
        cmd.bis_init = 1'b1;
        state_next = S_BA;
      end
      S_BA: begin
        cmd.bis_a = 1'b1;
        state_next = S_BB;
      end
      S_BB: begin
        cmd.bis_b = 1'b1;
        state_next = sts.bis_done ? S_MLO : S_BA;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/evt_dp.sv =====
// Datapath of the eased value transition block: state, divider, bisection,
// interpolation and result register. Driven by evt_ctrl; uses evt_pkg.
module evt_dp #(
  parameter int BISECT_STEPS = 24,
  parameter int TIME_BITS    = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [evt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          operation,
  input  logic [15:0]                   target_value,
  input  evt_pkg::dp_cmd_t               cmd,
  output evt_pkg::dp_sts_t               sts,
  output logic [15:0]                   current_value,
  output logic                          running,
  output logic                          finished
);
  import evt_pkg::*;

  localparam int Q_W  = TIME_BITS + 1;
  localparam int DC_W = $clog2(TIME_BITS + 1);
  localparam int BC_W = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;

  logic [19:0]             duration_ms;
  logic [16:0]             ctrl_x1, ctrl_x2;
  logic signed [17:0]      ctrl_y1, ctrl_y2;

  logic                    mode, fin, op_r;
  logic [15:0]             tgt_r;
  logic [19:0]             elapsed_ms, span_ms;
  logic [VAL_W-1:0]        begin_value, end_value, now_value;

  logic [20:0]             rem;
  logic [Q_W-1:0]          quot;
  logic [DC_W-1:0]         dcnt;

  logic signed [PT_W-1:0]  ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [PT_W-1:0]  abx, aby, cdx, cdy, lx, ly, rx, ry, ratio;
  logic [32:0]             t_val;
  logic [BC_W-1:0]         bcnt;

  logic signed [VAL_W:0]   vdiff;
  logic signed [45:0]      plo;
  logic signed [44:0]      phi;

  // Tick decision
  logic [19:0]             e1;
  logic                    done_tick;
  assign e1 = elapsed_ms + 20'd1;
  assign done_tick = (e1 > span_ms) || (e1 == '0);
  assign sts.need_ease = !op_r && mode && !done_tick;

  // Divider step
  logic [20:0]             span_x, rem_sub;
  logic                    qbit;
  assign span_x  = {1'b0, span_ms};
  assign qbit    = rem >= span_x;
  assign rem_sub = qbit ? rem - span_x : rem;
  assign sts.div_last = (dcnt == DC_W'(TIME_BITS));

  // Bisection, phase A
  logic signed [PT_W-1:0]  abx_c, aby_c, bcx_c, bcy_c, cdx_c, cdy_c;
  always_comb begin
    abx_c = half_floor({ax[PT_W-1], ax} + {bx[PT_W-1], bx});
    aby_c = half_floor({ay[PT_W-1], ay} + {by[PT_W-1], by});
    bcx_c = half_floor({bx[PT_W-1], bx} + {cx[PT_W-1], cx});
    bcy_c = half_floor({by[PT_W-1], by} + {cy[PT_W-1], cy});
    cdx_c = half_floor({cx[PT_W-1], cx} + {dx[PT_W-1], dx});
    cdy_c = half_floor({cy[PT_W-1], cy} + {dy[PT_W-1], dy});
  end

  // Bisection, phase B
  logic signed [PT_W-1:0]  mx_c, my_c;
  logic signed [PT_W+1:0]  tdiff;
  logic                    stop;
  assign mx_c  = half_floor({lx[PT_W-1], lx} + {rx[PT_W-1], rx});
  assign my_c  = half_floor({ly[PT_W-1], ly} + {ry[PT_W-1], ry});
  assign tdiff = $signed({5'b0, t_val}) - {{2{mx_c[PT_W-1]}}, mx_c};
  assign stop  = (tdiff > -(PT_W+2)'(TOL)) && (tdiff < (PT_W+2)'(TOL));
  assign sts.bis_done = stop || (bcnt == BC_W'(BISECT_STEPS - 1));

  // Interpolation
  logic signed [62:0]      prod;
  logic signed [30:0]      shv;
  logic signed [33:0]      vsum;
  assign prod = ({{18{phi[44]}}, phi} <<< 18) + {{17{plo[45]}}, plo};
  assign shv  = 31'(prod >>> 32);
  assign vsum = $signed({8'b0, begin_value}) + {{3{shv[30]}}, shv};

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms <= 20'd1000;
      ctrl_x1 <= 17'd16384;
      ctrl_y1 <= 18'sd6554;
      ctrl_x2 <= 17'd16384;
      ctrl_y2 <= 18'sd65536;
      mode <= 1'b0;
      fin <= 1'b0;
      elapsed_ms <= '0;
      span_ms <= '0;
      begin_value <= '0;
      end_value <= '0;
      now_value <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DURATION: duration_ms <= cfg_data;
          CFG_X1:       ctrl_x1 <= cfg_data[16:0];
          CFG_Y1:       ctrl_y1 <= $signed(cfg_data[17:0]);
          CFG_X2:       ctrl_x2 <= cfg_data[16:0];
          CFG_Y2:       ctrl_y2 <= $signed(cfg_data[17:0]);
          default: ;
        endcase
      end
      if (cmd.decide) begin
        fin <= 1'b0;
        if (op_r) begin
          if (mode) begin
            begin_value <= now_value;
            span_ms <= span_ms - elapsed_ms;
          end else begin
            span_ms <= duration_ms;
            now_value <= begin_value;
          end
          end_value <= {tgt_r, 10'b0};
          elapsed_ms <= '0;
          mode <= 1'b1;
        end else if (mode) begin
          elapsed_ms <= e1;
          if (done_tick) begin
            now_value <= end_value;
            begin_value <= end_value;
            mode <= 1'b0;
            fin <= 1'b1;
          end
        end
      end
      if (cmd.final_add) begin
        if (vsum < 0) now_value <= '0;
        else if (vsum > $signed({8'b0, {VAL_W{1'b1}}})) now_value <= '1;
        else now_value <= vsum[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= operation;
      tgt_r <= target_value;
    end
    if (cmd.decide) begin
      rem <= {1'b0, e1};
      quot <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      quot <= {quot[Q_W-2:0], qbit};
      rem <= {rem_sub[19:0], 1'b0};
      dcnt <= dcnt + DC_W'(1);
    end
    if (cmd.bis_init) begin
      ax <= '0;
      ay <= '0;
      bx <= $signed({3'b0, ctrl_x1, 16'b0});
      by <= $signed({{2{ctrl_y1[17]}}, ctrl_y1, 16'b0});
      cx <= $signed({3'b0, ctrl_x2, 16'b0});
      cy <= $signed({{2{ctrl_y2[17]}}, ctrl_y2, 16'b0});
      dx <= PT_W'(64'sd1 <<< 32);
      dy <= PT_W'(64'sd1 <<< 32);
      t_val <= 33'(quot) << (32 - TIME_BITS);
      bcnt <= '0;
    end
    if (cmd.bis_a) begin
      abx <= abx_c;
      aby <= aby_c;
      cdx <= cdx_c;
      cdy <= cdy_c;
      lx <= half_floor({abx_c[PT_W-1], abx_c} + {bcx_c[PT_W-1], bcx_c});
      ly <= half_floor({aby_c[PT_W-1], aby_c} + {bcy_c[PT_W-1], bcy_c});
      rx <= half_floor({bcx_c[PT_W-1], bcx_c} + {cdx_c[PT_W-1], cdx_c});
      ry <= half_floor({bcy_c[PT_W-1], bcy_c} + {cdy_c[PT_W-1], cdy_c});
    end
    if (cmd.bis_b) begin
      ratio <= my_c;
      bcnt <= bcnt + BC_W'(1);
      if (tdiff < 0) begin
        bx <= abx; by <= aby; cx <= lx; cy <= ly; dx <= mx_c; dy <= my_c;
      end else begin
        ax <= mx_c; ay <= my_c; bx <= rx; by <= ry; cx <= cdx; cy <= cdy;
      end
    end
    if (cmd.mul_lo) begin
      vdiff <= $signed({1'b0, end_value}) - $signed({1'b0, begin_value});
    end
    if (cmd.mul_hi) begin
      plo <= vdiff * $signed({1'b0, ratio[17:0]});
      phi <= vdiff * $signed(ratio[PT_W-1:18]);
    end
    if (cmd.out_load) begin
      current_value <= now_value[VAL_W-1:10];
      running <= mode;
      finished <= fin;
    end
  end

endmodule

// ===== src/eased_value_transition_top.sv =====
// Top level of the eased value transition block.
// Instantiates evt_ctrl and evt_dp; uses evt_pkg.
//
// This block moves a pixel length toward a target along a cubic Bezier easing
// curve. A request with operation 1 starts a move (or retargets one in
// progress), and a request with operation 0 is one millisecond tick; every
// request produces exactly one result with the current value, a running flag
// and a finished flag. Requests are taken one at a time. A run, an idle tick
// or a completing tick passes only through the decide and output states; an
// easing tick also runs the bit-serial divider that forms t, the de Casteljau
// bisection step (phases A and B) repeated up to BISECT_STEPS times, and the
// split interpolation multiply. The result waits in an output register while
// the next request is accepted. Configuration writes are always ready and
// must only be issued while the block is idle.
module eased_value_transition_top #(
  parameter int BISECT_STEPS = 24,
  parameter int TIME_BITS    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] target_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] current_value,
  output logic        running,
  output logic        finished
);
  import evt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  evt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  evt_dp #(
    .BISECT_STEPS (BISECT_STEPS),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .target_value  (target_value),
    .cmd           (cmd),
    .sts           (sts),
    .current_value (current_value),
    .running       (running),
    .finished      (finished)
  );

endmodule
